// File: rtl/pfp_pkg.sv
// Shared types and constants for the particle sensor frame parser.
`timescale 1ns / 1ps
`default_nettype none

package pfp_pkg;

    localparam int          MEASUREMENT_WORDS_DEF = 12;
    localparam int          WORD_INDEX_W          = 4;
    localparam logic [7:0]  START_BYTE_RESET      = 8'h42;

    // frame byte positions
    localparam logic [4:0]  POS_AFTER_START = 5'd1;
    localparam logic [4:0]  POS_FIRST_LO    = 5'd5;   // low byte of first measurement word
    localparam logic [4:0]  POS_CHK_HI      = 5'd30;
    localparam logic [4:0]  POS_CHK_LO      = 5'd31;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_FRAME,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;      // start byte accepted while hunting
        logic take;       // frame byte accepted
        logic load_word;  // load next stored word into the output register
        logic load_err;   // load the checksum failure item
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic start_match;
        logic pos_last;
        logic sum_ok;
        logic idx_last;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/pfp_datapath.sv
// Datapath: frame byte handling, checksum, measurement store and output register.
`timescale 1ns / 1ps
`default_nettype none

module pfp_datapath #(
    parameter int MEASUREMENT_WORDS = pfp_pkg::MEASUREMENT_WORDS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [7:0]                      i_cfg_wdata,
    input  wire logic [7:0]                      i_rx_byte,
    input  wire pfp_pkg::t_cmd                   i_cmd,
    output pfp_pkg::t_sts                        o_sts,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic [pfp_pkg::WORD_INDEX_W-1:0]     o_word_index,
    output logic [15:0]                          o_word_value,
    output logic                                 o_frame_ok,
    output logic                                 o_last
);

    localparam int IDX_W = (MEASUREMENT_WORDS > 1) ? $clog2(MEASUREMENT_WORDS) : 1;

    logic [7:0]        r_start_byte;
    logic [4:0]        r_pos;
    logic [15:0]       r_sum;
    logic [7:0]        r_hi;
    logic [7:0]        r_chk_hi;
    logic              r_sum_ok;
    logic [IDX_W-1:0]  r_idx;
    logic [15:0]       r_store [0:MEASUREMENT_WORDS-1];

    logic                                r_out_valid;
    logic [pfp_pkg::WORD_INDEX_W-1:0]    r_out_index;
    logic [15:0]                         r_out_value;
    logic                                r_out_ok;
    logic                                r_out_last;

    logic [4:0] pos_off;
    logic [3:0] wr_k;
    logic       wr_en;
    logic       idx_last;

    assign pos_off  = r_pos - pfp_pkg::POS_FIRST_LO;
    assign wr_k     = pos_off[4:1];
    assign wr_en    = r_pos[0] && (r_pos >= pfp_pkg::POS_FIRST_LO)
                      && (int'(wr_k) < MEASUREMENT_WORDS);
    assign idx_last = (r_idx == IDX_W'(MEASUREMENT_WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= pfp_pkg::START_BYTE_RESET;
        end else if (i_cfg_we) begin
            r_start_byte <= i_cfg_wdata;
        end
    end

    // frame byte processing; payload registers need no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos <= pfp_pkg::POS_AFTER_START;
            r_sum <= {8'd0, i_rx_byte};
        end else if (i_cmd.take) begin
            r_pos <= r_pos + 5'd1;
            if (r_pos < pfp_pkg::POS_CHK_HI) begin
                r_sum <= r_sum + {8'd0, i_rx_byte};
                if (!r_pos[0]) begin
                    r_hi <= i_rx_byte;
                end
            end else if (r_pos == pfp_pkg::POS_CHK_HI) begin
                r_chk_hi <= i_rx_byte;
            end else begin
                r_sum_ok <= ({r_chk_hi, i_rx_byte} == r_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (r_pos < pfp_pkg::POS_CHK_HI) && wr_en) begin
            r_store[wr_k[IDX_W-1:0]] <= {r_hi, i_rx_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.take && (r_pos == pfp_pkg::POS_CHK_LO)) begin
            r_idx <= '0;
        end else if (i_cmd.load_word && !idx_last) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // output register: refilled when empty or when its item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_word || i_cmd.load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_out_index <= pfp_pkg::WORD_INDEX_W'(r_idx);
            r_out_value <= r_store[r_idx];
            r_out_ok    <= 1'b1;
            r_out_last  <= idx_last;
        end else if (i_cmd.load_err) begin
            r_out_index <= '0;
            r_out_value <= '0;
            r_out_ok    <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    always_comb begin
        o_sts.start_match = (i_rx_byte == r_start_byte);
        o_sts.pos_last    = (r_pos == pfp_pkg::POS_CHK_LO);
        o_sts.sum_ok      = r_sum_ok;
        o_sts.idx_last    = idx_last;
        o_sts.out_busy    = r_out_valid && !i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_word_index = r_out_index;
    assign o_word_value = r_out_value;
    assign o_frame_ok   = r_out_ok;
    assign o_last       = r_out_last;

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_last && (r_out_value == 16'd0)
                                        && (r_out_index == '0)))
        else $error("failure item malformed");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ok) |->
            (int'(r_out_index) < MEASUREMENT_WORDS)
            && (r_out_last == (int'(r_out_index) == MEASUREMENT_WORDS - 1)))
        else $error("word index out of range or last misplaced");

endmodule

`default_nettype wire

// File: rtl/pfp_ctrl.sv
// Controller: hunt / frame / emit sequencing.
`timescale 1ns / 1ps
`default_nettype none

module pfp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire pfp_pkg::t_sts  i_sts,
    output pfp_pkg::t_cmd       o_cmd
);

    pfp_pkg::t_state r_state;
    pfp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfp_pkg::ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            pfp_pkg::ST_HUNT: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_sts.start_match) begin
                    o_cmd.start = 1'b1;
                    n_state     = pfp_pkg::ST_FRAME;
                end
            end
            pfp_pkg::ST_FRAME: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.pos_last) begin
                        n_state = pfp_pkg::ST_EMIT;
                    end
                end
            end
            pfp_pkg::ST_EMIT: begin
                if (!i_sts.out_busy) begin
                    if (!i_sts.sum_ok) begin
                        o_cmd.load_err = 1'b1;
                        n_state        = pfp_pkg::ST_HUNT;
                    end else begin
                        o_cmd.load_word = 1'b1;
                        if (i_sts.idx_last) begin
                            n_state = pfp_pkg::ST_HUNT;
                        end
                    end
                end
            end
            default: begin
                n_state = pfp_pkg::ST_HUNT;
            end
        endcase
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_word || o_cmd.load_err) |-> !i_sts.out_busy)
        else $error("output register overwritten while held");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfp_pkg::ST_FRAME && i_in_valid && i_sts.pos_last)
            |=> (r_state == pfp_pkg::ST_EMIT) && !o_in_ready)
        else $error("final frame byte did not lead to emission");

endmodule

`default_nettype wire

// File: rtl/particle_sensor_frame_parser_unit.sv
// Top level of the particle sensor frame parser.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] rx_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata word_index, word_value; tuser frame_ok;
//                                              tlast last
//  cfg       in   i_cfg_we                     i_cfg_wdata start_byte
//
// One received byte accepted per cycle while hunting or inside a frame.
// After byte 31 input stalls while the run leaves the output register:
// one word per cycle while m_axis_tready is high (MEASUREMENT_WORDS, 12 by default,
// for a good frame, 1 for a checksum failure), as sequenced by the controller's emit state.
// Synchronous active-low reset; no clearing pass. start_byte resets to 0x42.
`timescale 1ns / 1ps
`default_nettype none

module particle_sensor_frame_parser_unit #(
    parameter int MEASUREMENT_WORDS = pfp_pkg::MEASUREMENT_WORDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [3:0] word_index, [19:4] word_value, zero
    output logic             m_axis_tuser,   // frame_ok
    output logic             m_axis_tlast
);

    pfp_pkg::t_cmd cmd;
    pfp_pkg::t_sts sts;

    logic [pfp_pkg::WORD_INDEX_W-1:0] word_index;
    logic [15:0]                      word_value;

    pfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pfp_datapath #(
        .MEASUREMENT_WORDS (MEASUREMENT_WORDS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_rx_byte    (s_axis_tdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_word_index (word_index),
        .o_word_value (word_value),
        .o_frame_ok   (m_axis_tuser),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, word_value, word_index};

endmodule

`default_nettype wire
